// ----- src/bccp_pkg.sv -----
// Shared types, constants and elaboration-time tables for the capillary pressure unit.
`timescale 1ns / 1ps
package bccp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int PRES_BITS  = 32;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int SE_MIN_RAW = (ONE + 5000) / 10000;
    localparam int SE_MIN     = (SE_MIN_RAW > 0) ? SE_MIN_RAW : 1;
    localparam int SE_MAX     = ONE - SE_MIN;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_WET_SEL  = 3'd0,
        CFG_RESIDUAL = 3'd1,
        CFG_LAMBDA   = 3'd2,
        CFG_ENTRY    = 3'd3,
        CFG_PMAX     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic        wet_sel;
        logic [15:0] residual;
        logic [15:0] lambda;
        logic [31:0] entry;
        logic [31:0] pmax;
    } t_cfg;

    // how effective saturation is to be formed
    typedef enum logic [1:0] {
        SE_DIV,
        SE_LOW,
        SE_HIGH
    } t_se_kind;

    typedef struct packed {
        t_se_kind    kind;
        logic [15:0] diff;
    } t_cell;

    typedef logic [16:1][30:0] t_root_tab;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        logic [63:0] vv;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        vv  = v;
        for (int i = 0; i < 32; i++) begin
            if (vv >= res + b) begin
                vv  = vv - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q30 for k = 1..16
    function automatic t_root_tab root_table();
        t_root_tab   tab;
        logic [63:0] r;
        r = 64'h8000_0000;
        for (int k = 1; k <= 16; k++) begin
            r = isqrt64(r << 30);
            tab[k] = r[30:0];
        end
        return tab;
    endfunction

    localparam t_root_tab ROOT_TAB = root_table();

endpackage

// ----- src/bccp_front.sv -----
// Input stage: picks the wetting fraction and classifies the effective saturation case.
`timescale 1ns / 1ps
module bccp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bccp_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [16:0]     i_phase_one_fraction,
    input  logic [16:0]     i_phase_two_fraction,
    output logic            o_push,
    output bccp_pkg::t_cell o_cell,
    input  logic            i_full
);
    import bccp_pkg::*;

    logic        r_fv;
    t_cell       r_cell;
    t_cell       n_cell;
    logic [16:0] s;
    logic [16:0] diff;
    logic [16:0] dvs;

    assign o_push  = r_fv && !i_full;
    assign o_ready = !r_fv || !i_full;
    assign o_cell  = r_cell;

    always_comb begin
        s    = i_cfg.wet_sel ? i_phase_two_fraction : i_phase_one_fraction;
        diff = s - {1'b0, i_cfg.residual};
        dvs  = 17'(ONE) - {1'b0, i_cfg.residual};
        n_cell.diff = diff[15:0];
        if (s <= {1'b0, i_cfg.residual}) begin
            n_cell.kind = SE_LOW;
        end else if (diff >= dvs) begin
            n_cell.kind = SE_HIGH;
        end else begin
            n_cell.kind = SE_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cell <= n_cell;
        end
    end

endmodule

// ----- src/bccp_fifo.sv -----
// Four-entry queue between the front stage and the arithmetic pipeline.
`timescale 1ns / 1ps
module bccp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bccp_pkg::t_cell i_data,
    output logic            o_full,
    input  logic            i_pop,
    output bccp_pkg::t_cell o_data,
    output logic            o_empty
);
    import bccp_pkg::*;

    t_cell      r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 3'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- src/bccp_back.sv -----
// Arithmetic pipeline: Se divide, log2, exponent divide, exp2, scale and clamp.
`timescale 1ns / 1ps
module bccp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bccp_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  bccp_pkg::t_cell i_cell,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_pressure,
    output logic            o_clamped
);
    import bccp_pkg::*;

    localparam int NA    = 16;
    localparam int NC    = 16;
    localparam int ND    = 29;
    localparam int NE    = 16;
    localparam int DEPTH = NA + 1 + NC + ND + NE + 4;

    logic             en;
    logic [DEPTH-1:0] r_vld;

    assign en      = !r_vld[DEPTH-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    // ---------------- Se = diff * ONE / (ONE - residual), one quotient bit a stage
    logic [16:0] se_dvs;
    logic [15:0] r_a_rem [NA];
    logic [15:0] r_a_q   [NA];
    t_se_kind    r_a_kind[NA];
    logic [15:0] a_rem_in[NA];
    logic [15:0] a_q_in  [NA];
    t_se_kind    a_kind_in[NA];
    logic [15:0] a_rem_nx[NA];
    logic        a_bit   [NA];
    logic [16:0] a_r2    [NA];

    assign se_dvs = 17'(ONE) - {1'b0, i_cfg.residual};

    always_comb begin
        a_rem_in[0]  = i_cell.diff;
        a_q_in[0]    = '0;
        a_kind_in[0] = i_cell.kind;
        for (int j = 1; j < NA; j++) begin
            a_rem_in[j]  = r_a_rem[j-1];
            a_q_in[j]    = r_a_q[j-1];
            a_kind_in[j] = r_a_kind[j-1];
        end
        for (int j = 0; j < NA; j++) begin
            a_r2[j] = {a_rem_in[j], 1'b0};
            if (a_r2[j] >= se_dvs) begin
                a_rem_nx[j] = 16'(a_r2[j] - se_dvs);
                a_bit[j]    = 1'b1;
            end else begin
                a_rem_nx[j] = a_r2[j][15:0];
                a_bit[j]    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < NA; j++) begin
                r_a_rem[j]  <= a_rem_nx[j];
                r_a_q[j]    <= {a_q_in[j][14:0], a_bit[j]};
                r_a_kind[j] <= a_kind_in[j];
            end
        end
    end

    // ---------------- clamp and normalize to Q1.30
    logic [15:0] se;
    logic [3:0]  b_p;
    logic [30:0] r_b_y;
    logic [3:0]  r_b_p;

    always_comb begin
        case (r_a_kind[NA-1])
            SE_LOW:  se = 16'(SE_MIN);
            SE_HIGH: se = 16'(SE_MAX);
            SE_DIV: begin
                if (r_a_q[NA-1] < 16'(SE_MIN)) begin
                    se = 16'(SE_MIN);
                end else if (r_a_q[NA-1] > 16'(SE_MAX)) begin
                    se = 16'(SE_MAX);
                end else begin
                    se = r_a_q[NA-1];
                end
            end
            default: se = 16'(SE_MIN);
        endcase
        b_p = '0;
        for (int k = 0; k < 16; k++) begin
            if (se[k]) begin
                b_p = 4'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_p <= b_p;
            r_b_y <= {15'd0, se} << (5'd30 - {1'b0, b_p});
        end
    end

    // ---------------- log2 fraction, one squaring a stage
    logic [30:0] r_c_y[NC];
    logic [15:0] r_c_f[NC];
    logic [3:0]  r_c_p[NC];
    logic [30:0] c_y_in[NC];
    logic [15:0] c_f_in[NC];
    logic [3:0]  c_p_in[NC];
    logic [61:0] c_sq  [NC];

    always_comb begin
        c_y_in[0] = r_b_y;
        c_f_in[0] = '0;
        c_p_in[0] = r_b_p;
        for (int j = 1; j < NC; j++) begin
            c_y_in[j] = r_c_y[j-1];
            c_f_in[j] = r_c_f[j-1];
            c_p_in[j] = r_c_p[j-1];
        end
        for (int j = 0; j < NC; j++) begin
            c_sq[j] = 62'(c_y_in[j]) * 62'(c_y_in[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < NC; j++) begin
                r_c_p[j] <= c_p_in[j];
                if (c_sq[j][61]) begin
                    r_c_y[j] <= c_sq[j][61:31];
                    r_c_f[j] <= {c_f_in[j][14:0], 1'b1};
                end else begin
                    r_c_y[j] <= c_sq[j][60:30];
                    r_c_f[j] <= {c_f_in[j][14:0], 1'b0};
                end
            end
        end
    end

    // ---------------- exponent e = neg * 256 / lambda, one quotient bit a stage
    logic [16:0] lam;
    logic [20:0] neg;
    logic [28:0] r_d_num[ND];
    logic [15:0] r_d_rem[ND];
    logic [28:0] r_d_q  [ND];
    logic [28:0] d_num_in[ND];
    logic [15:0] d_rem_in[ND];
    logic [28:0] d_q_in  [ND];
    logic [16:0] d_r2    [ND];
    logic [15:0] d_rem_nx[ND];
    logic        d_bit   [ND];

    assign lam = (i_cfg.lambda == 16'd0) ? 17'd1 : {1'b0, i_cfg.lambda};
    assign neg = 21'(FRAC_BITS << 16) - {1'b0, r_c_p[NC-1], r_c_f[NC-1]};

    always_comb begin
        d_num_in[0] = {neg[20:0], 8'd0};
        d_rem_in[0] = '0;
        d_q_in[0]   = '0;
        for (int j = 1; j < ND; j++) begin
            d_num_in[j] = r_d_num[j-1];
            d_rem_in[j] = r_d_rem[j-1];
            d_q_in[j]   = r_d_q[j-1];
        end
        for (int j = 0; j < ND; j++) begin
            d_r2[j] = {d_rem_in[j], d_num_in[j][28]};
            if (d_r2[j] >= lam) begin
                d_rem_nx[j] = 16'(d_r2[j] - lam);
                d_bit[j]    = 1'b1;
            end else begin
                d_rem_nx[j] = d_r2[j][15:0];
                d_bit[j]    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < ND; j++) begin
                r_d_num[j] <= {d_num_in[j][27:0], 1'b0};
                r_d_rem[j] <= d_rem_nx[j];
                r_d_q[j]   <= {d_q_in[j][27:0], d_bit[j]};
            end
        end
    end

    // ---------------- exp2 of the fraction, one root factor a stage
    logic [30:0] r_e_m [NE];
    logic [15:0] r_e_fr[NE];
    logic [12:0] r_e_i [NE];
    logic [30:0] e_m_in [NE];
    logic [15:0] e_fr_in[NE];
    logic [12:0] e_i_in [NE];
    logic [61:0] e_prod [NE];

    always_comb begin
        e_m_in[0]  = 31'h4000_0000;
        e_fr_in[0] = r_d_q[ND-1][15:0];
        e_i_in[0]  = r_d_q[ND-1][28:16];
        for (int j = 1; j < NE; j++) begin
            e_m_in[j]  = r_e_m[j-1];
            e_fr_in[j] = r_e_fr[j-1];
            e_i_in[j]  = r_e_i[j-1];
        end
        for (int j = 0; j < NE; j++) begin
            e_prod[j] = 62'(e_m_in[j]) * 62'(ROOT_TAB[j+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < NE; j++) begin
                r_e_fr[j] <= e_fr_in[j];
                r_e_i[j]  <= e_i_in[j];
                r_e_m[j]  <= e_fr_in[j][15-j] ? e_prod[j][60:30] : e_m_in[j];
            end
        end
    end

    // ---------------- scale by entry pressure and 2^i, saturate, clamp
    localparam logic [32:0] P_OVER = 33'h1_0000_0000;

    logic [46:0] r_p1_a;
    logic [46:0] r_p1_b;
    logic [12:0] r_p1_i;
    logic [62:0] r_p2_x;
    logic [12:0] r_p2_i;
    logic [32:0] r_p3_v;
    logic [32:0] p3_v;
    logic [12:0] p3_t;
    logic [4:0]  p3_sh;
    logic [62:0] p3_xs;
    logic [62:0] p3_xr;
    logic [31:0] r_o_p;
    logic        r_o_c;

    always_comb begin
        p3_t  = r_p2_i - 13'd30;
        p3_sh = 5'(13'd30 - r_p2_i);
        p3_xs = r_p2_x << p3_t[5:0];
        p3_xr = r_p2_x >> p3_sh;
        if (r_p2_i >= 13'd30) begin
            if (r_p2_x == '0) begin
                p3_v = '0;
            end else if (p3_t >= 13'd33 || r_p2_x > 63'(P_OVER >> p3_t[5:0])) begin
                p3_v = P_OVER;
            end else begin
                p3_v = p3_xs[32:0];
            end
        end else begin
            p3_v = (p3_xr > 63'(P_OVER)) ? P_OVER : p3_xr[32:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_a <= 47'(i_cfg.entry[31:16]) * 47'(r_e_m[NE-1]);
            r_p1_b <= 47'(i_cfg.entry[15:0]) * 47'(r_e_m[NE-1]);
            r_p1_i <= r_e_i[NE-1];
            r_p2_x <= {r_p1_a[46:0], 16'd0} + 63'(r_p1_b);
            r_p2_i <= r_p1_i;
            r_p3_v <= p3_v;
            if (r_p3_v > {1'b0, i_cfg.pmax}) begin
                r_o_p <= i_cfg.pmax;
                r_o_c <= 1'b1;
            end else begin
                r_o_p <= r_p3_v[31:0];
                r_o_c <= 1'b0;
            end
        end
    end

    assign o_pressure = r_o_p;
    assign o_clamped  = r_o_c;

endmodule

// ----- src/brooks_corey_capillary_pressure_unit.sv -----
// Top level of the Brooks-Corey capillary pressure unit: registers, front stage, queue, pipeline.
`timescale 1ns / 1ps
// Takes one mesh cell per cycle unless the output stalls, and returns entry_pressure *
// Se^(-1/lambda) as unsigned Q24.8, one result per cell, in order. From the front register to
// the output register there are 16 Se divide stages, 1 normalize, 16 log2 squarings, 29 exponent
// divide stages, 16 exp2 root stages and 4 scale/clamp stages; a four-item queue sits between
// the front stage and the pipeline. Sustained rate is one item per clock unless the output stalls.
// There is no clearing pass after reset. Write configuration only while no item is in flight.
module brooks_corey_capillary_pressure_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [16:0] phase_one_fraction, [33:17] phase_two_fraction
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] capillary_pressure
    output logic        m_axis_tuser,   // [0] pressure_clamped
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import bccp_pkg::*;

    t_cfg  r_cfg;
    t_cell f_cell;
    t_cell q_cell;
    logic  f_push;
    logic  q_full;
    logic  q_empty;
    logic  b_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wet_sel  <= 1'b0;
            r_cfg.residual <= 16'd3277;
            r_cfg.lambda   <= 16'd512;
            r_cfg.entry    <= 32'd256;
            r_cfg.pmax     <= 32'hFFFF_FFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WET_SEL:  r_cfg.wet_sel  <= i_cfg_data[0];
                CFG_RESIDUAL: r_cfg.residual <= i_cfg_data[15:0];
                CFG_LAMBDA:   r_cfg.lambda   <= i_cfg_data[15:0];
                CFG_ENTRY:    r_cfg.entry    <= i_cfg_data;
                CFG_PMAX:     r_cfg.pmax     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bccp_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_valid              (s_axis_tvalid),
        .o_ready              (s_axis_tready),
        .i_phase_one_fraction (s_axis_tdata[16:0]),
        .i_phase_two_fraction (s_axis_tdata[33:17]),
        .o_push               (f_push),
        .o_cell               (f_cell),
        .i_full               (q_full)
    );

    bccp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_cell),
        .o_full  (q_full),
        .i_pop   (b_ready && !q_empty),
        .o_data  (q_cell),
        .o_empty (q_empty)
    );

    bccp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (!q_empty),
        .o_ready    (b_ready),
        .i_cell     (q_cell),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_pressure (m_axis_tdata),
        .o_clamped  (m_axis_tuser)
    );

endmodule

// ----- tb/sv/brooks_corey_capillary_pressure_unit_tb.sv -----
// Testbench for the capillary pressure unit: directed and random cells checked against a local predictor.
`timescale 1ns / 1ps
module brooks_corey_capillary_pressure_unit_tb;
    import bccp_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    typedef struct {
        logic [31:0] pressure;
        logic        clamped;
    } t_pressure_item;

    t_pressure_item pressure_q[$];
    int err_cnt = 0;
    int cell_cnt = 0;
    int result_cnt = 0;
    int clamp_cnt = 0;
    bit rx_stall_off = 1'b0;

    // local copy of the register file
    logic        m_wet_sel;
    logic [15:0] m_residual;
    logic [15:0] m_lambda;
    logic [31:0] m_entry;
    logic [31:0] m_pmax;

    brooks_corey_capillary_pressure_unit dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] sat_shl(input logic [63:0] x, input logic [63:0] n);
        if (x == 0) return 0;
        if (n >= 63 || x > ((64'd1 << 32) >> n)) return 64'd1 << 32;
        return x << n;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > (64'd1 << 32)) ? (64'd1 << 32) : s;
    endfunction

    function automatic t_pressure_item predict_pressure(input logic [16:0] f1,
                                                        input logic [16:0] f2);
        t_pressure_item r;
        logic [63:0] s, srw, lam, se, lg, y, neg, e, ei, m, rt, a, b, v, sh;
        int p;
        s = m_wet_sel ? f2 : f1;
        srw = m_residual;
        lam = (m_lambda == 0) ? 1 : m_lambda;
        se = (s > srw) ? ((s - srw) << 16) / (64'd65536 - srw) : 0;
        if (se < SE_MIN) se = SE_MIN;
        if (se > SE_MAX) se = SE_MAX;
        p = 0;
        while ((se >> (p + 1)) != 0) p++;
        y = se << (30 - p);
        lg = 0;
        for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 30;
            lg = lg << 1;
            if (y >= (64'd2 << 30)) begin
                y = y >> 1;
                lg = lg | 1;
            end
        end
        lg = lg + (64'(p) << 16);
        neg = (64'd16 << 16) - lg;
        e = (neg << 8) / lam;
        ei = e >> 16;
        m = 64'd1 << 30;
        rt = 64'd2 << 30;
        for (int k = 1; k <= 16; k++) begin
            rt = int_sqrt(rt << 30);
            if (e[16 - k]) m = (m * rt) >> 30;
        end
        a = (m_entry >> 16) * m;
        b = (m_entry & 32'hFFFF) * m;
        if (ei >= 30) begin
            v = sat_add(sat_shl(a, ei - 30 + 16), sat_shl(b, ei - 30));
        end else begin
            sh = 30 - ei;
            if (sh >= 16) begin
                v = (a + (b >> 16)) >> (sh - 16);
                if (v > (64'd1 << 32)) v = 64'd1 << 32;
            end else begin
                v = sat_add(sat_shl(a, 16 - sh), b >> sh);
            end
        end
        if (v > m_pmax) begin
            r.pressure = m_pmax;
            r.clamped = 1'b1;
        end else begin
            r.pressure = v[31:0];
            r.clamped = 1'b0;
        end
        return r;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WET_SEL:  m_wet_sel = val[0];
            CFG_RESIDUAL: m_residual = val[15:0];
            CFG_LAMBDA:   m_lambda = val[15:0];
            CFG_ENTRY:    m_entry = val;
            CFG_PMAX:     m_pmax = val;
            default: ;
        endcase
    endtask

    // out-of-range index, must be ignored
    task automatic write_bad_index();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= 3'd7;
        i_cfg_data <= '1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // tvalid stays high after an accept; the next call drops it only for a gap, and drain() drops it
    task automatic send_cell(input logic [16:0] f1, input logic [16:0] f2, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, f2, f1};
        pressure_q.push_back(predict_pressure(f1, f2));
        do @(posedge i_clk); while (!s_axis_tready);
        cell_cnt++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pressure_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // random fraction, mostly in [0, ONE], sometimes any 17-bit value
    function automatic logic [16:0] rand_frac();
        case ($urandom_range(0, 9))
            0: return 17'($urandom);
            1: return 17'd65536;
            2: return 17'($urandom_range(0, 3000));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic test_directed();
        logic [16:0] vals[8];
        vals = '{17'd0, 17'd1, 17'd3277, 17'd3278, 17'd32768, 17'd65535, 17'd65536,
                 17'h1FFFF};
        foreach (vals[i]) send_cell(vals[i], vals[7 - i], 1'b0);
        drain();
        write_reg(CFG_WET_SEL, 32'hFFFF_FFFE); // only bit 0 counts
        write_reg(CFG_LAMBDA, 32'd0);          // floored to 1/256
        write_bad_index();
        send_cell(17'd65536, 17'd100, 1'b1);
        send_cell(17'd0, 17'd40000, 1'b1);
        drain();
        write_reg(CFG_WET_SEL, 32'd1);
        write_reg(CFG_RESIDUAL, 32'd65535);
        write_reg(CFG_LAMBDA, 32'd65535);
        write_reg(CFG_ENTRY, 32'hFFFF_FFFF);
        write_reg(CFG_PMAX, 32'd1000);
        send_cell(17'd0, 17'd65536, 1'b0);
        send_cell(17'd0, 17'h1FFFF, 1'b0);
        send_cell(17'h1FFFF, 17'd0, 1'b0);
        drain();
        write_reg(CFG_RESIDUAL, 32'd0);
        write_reg(CFG_LAMBDA, 32'd1);
        write_reg(CFG_ENTRY, 32'd0);
        write_reg(CFG_PMAX, 32'd0);
        send_cell(17'd5, 17'd5, 1'b0);
        send_cell(17'd65536, 17'd65536, 1'b0);
        drain();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_WET_SEL, $urandom);
            write_reg(CFG_RESIDUAL, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8000));
            write_reg(CFG_LAMBDA, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1024));
            write_reg(CFG_ENTRY, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20));
            write_reg(CFG_PMAX, $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom);
            rx_stall_off = (ph % 3 == 2);
            for (int i = 0; i < 50; i++) send_cell(rand_frac(), rand_frac(), ph % 3 != 2);
            drain();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_pressure_item exp_item;
            if (pressure_q.size() == 0) begin
                $error("result with no cell pending: pressure %0d", m_axis_tdata);
                err_cnt++;
            end else begin
                exp_item = pressure_q.pop_front();
                result_cnt++;
                if (exp_item.clamped) clamp_cnt++;
                if (m_axis_tdata !== exp_item.pressure) begin
                    $error("capillary_pressure expected %0d actual %0d",
                           exp_item.pressure, m_axis_tdata);
                    err_cnt++;
                end
                if (m_axis_tuser !== exp_item.clamped) begin
                    $error("pressure_clamped expected %0d actual %0d",
                           exp_item.clamped, m_axis_tuser);
                    err_cnt++;
                end
            end
        end
    end

    // receiver: random stall lengths per item, none while rx_stall_off
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = rx_stall_off ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        m_wet_sel = 1'b0;
        m_residual = 16'd3277;
        m_lambda = 16'd512;
        m_entry = 32'd256;
        m_pmax = 32'hFFFF_FFFF;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        if (pressure_q.size() != 0) begin
            $error("%0d results never arrived", pressure_q.size());
            err_cnt++;
        end
        $display("Sent %0d cells, checked %0d results, %0d hit the pressure limit.",
                 cell_cnt, result_cnt, clamp_cnt);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
